/* src/jdqr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jdqr_pkg;

   // Table geometry
   localparam int TABLE_ENTRIES      = 64;
   localparam int TABLE_START_OFFSET = 5;
   localparam int MAX_TABLES         = 16;

   localparam int POS_W   = 7;
   localparam int COUNT_W = $clog2(MAX_TABLES + 1);
   localparam int SCALE_W = 13;
   localparam int PROD_W  = SCALE_W + 8;
   localparam int QUOT_W  = 15;

   localparam logic [POS_W-1:0] WIN_FIRST = POS_W'(TABLE_START_OFFSET);
   localparam logic [POS_W-1:0] WIN_LAST  = POS_W'(TABLE_START_OFFSET + TABLE_ENTRIES - 1);
   localparam logic [POS_W-1:0] WIN_END   = POS_W'(TABLE_START_OFFSET + TABLE_ENTRIES);

   // Marker bytes
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_DQT    = 8'hDB;

   // Rounding and clamping of (S*v+50)/100
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(50);
   localparam logic [PROD_W-1:0] DIV_ONE    = PROD_W'(100);
   localparam logic [PROD_W-1:0] DIV_SAT    = PROD_W'(25600);
   localparam logic [QUOT_W-1:0] RECIP_100  = QUOT_W'(20972);
   localparam int                RECIP_SHIFT = 21;
   localparam logic [7:0]        ENTRY_MIN  = 8'd1;
   localparam logic [7:0]        ENTRY_MAX  = 8'd255;

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUALITY      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SELECT = 2'd1;

   localparam logic [6:0]         QUALITY_RESET = 7'd50;
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 13'd100;

   // 5000/q for q below 50; quality zero reads as quality one
   localparam logic [SCALE_W-1:0] LOW_Q_SCALE [64] = '{
      13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714,
      13'd625,  13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357, 13'd333,
      13'd312,  13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227, 13'd217,
      13'd208,  13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166, 13'd161,
      13'd156,  13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131, 13'd128,
      13'd125,  13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108, 13'd106,
      13'd104,  13'd102,  13'd0,    13'd0,    13'd0,    13'd0,    13'd0,   13'd0,
      13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,   13'd0
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       rewritten;
   } rsp_type;

   function automatic logic [SCALE_W-1:0] scale_lookup(input logic [6:0] q);
      logic [SCALE_W-1:0] s;
      if (q < 7'd50) begin
         s = LOW_Q_SCALE[q[5:0]];
      end else if (q <= 7'd100) begin
         s = SCALE_W'(200) - SCALE_W'({q, 1'b0});
      end else begin
         s = '0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

/* src/jpeg_dqt_quality_rescaler.sv */
`timescale 1ns / 1ps
`default_nettype none

// JPEG DQT quality rescaler.
// Feed the file one byte per request on the req_ channel (data_byte plus an
// end_of_file flag on the final byte). Every byte comes back on the rsp_
// channel in order: passed through, or, inside the 64-entry window of the
// selected FF DB table, replaced by (S*v+50)/100 clamped to 1..255, with
// rewritten set. S follows quality (5000/q below 50, 200-2q up to 100, zero
// above), taken when no table is open or the selected one restarts, else held.
// csr_ writes quality (index 0) and table_select (index 1); write only while
// the block is idle. csr_ready is always high.
// A request accepted on req_ passes the middle stage register and then the
// result register before it shows on rsp_.
// Throughput: one byte per clock while the receiver does not stall; the two stages
// are the scale multiply and the reciprocal multiply that divides by 100.
// Reset (synchronous, active high) empties both stages, clears the marker
// tracking and loads quality 50 and table_select 0.
// When the receiver stalls, the result register holds, the middle stage
// fills, and req_ready drops only once both are full.
module jpeg_dqt_quality_rescaler (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire jdqr_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output jdqr_pkg::rsp_type     rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [jdqr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [jdqr_pkg::CSR_DATA_W-1:0]  csr_data
);
   import jdqr_pkg::*;

   // configuration
   logic [6:0] quality_ff, quality_in;
   logic [3:0] tsel_ff, tsel_in;

   // stream tracking state
   logic               prev_ff_ff, prev_ff_in;
   logic [POS_W-1:0]   seg_ff, seg_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   // middle stage
   logic              stg_valid_ff, stg_valid_in;
   logic [PROD_W-1:0] stg_prod_ff, stg_prod_in;
   logic [7:0]        stg_byte_ff;
   logic              stg_last_ff;
   logic              stg_rew_ff, stg_rew_in;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   logic               req_fire, stg_advance, rsp_free;
   logic               marker, count_open, selected, in_window;
   logic [POS_W-1:0]   pos;
   logic [SCALE_W-1:0] scale_eff;
   logic [QUOT_W*2-1:0] quot_full;
   logic [7:0]         entry;

   assign csr_ready = 1'b1;

   // ---------------- handshake ----------------
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign stg_advance = stg_valid_ff && rsp_free;
   assign req_ready   = !stg_valid_ff || rsp_free;
   assign req_fire    = req_valid && req_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- configuration ----------------
   always_comb begin
      quality_in = quality_ff;
      tsel_in    = tsel_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_QUALITY:      quality_in = csr_data;
            CSR_TABLE_SELECT: tsel_in    = csr_data[3:0];
            default:          ;
         endcase
      end
   end

   // ---------------- marker tracking ----------------
   always_comb begin
      marker     = prev_ff_ff && (req_payload.data_byte == MARKER_DQT);
      count_open = count_ff < COUNT_W'(MAX_TABLES);
      selected   = marker && count_open && (count_ff == COUNT_W'(tsel_ff));

      // take a fresh scale when no table is open or the selected table restarts
      scale_eff = ((seg_ff == '0) || selected) ? scale_lookup(quality_ff) : scale_ff;

      if (selected) begin
         pos = POS_W'(1);
      end else if (marker) begin
         pos = '0;
      end else if (seg_ff != '0) begin
         pos = seg_ff + POS_W'(1);
      end else begin
         pos = '0;
      end

      in_window = (pos >= WIN_FIRST) && (pos < WIN_END);

      prev_ff_in = prev_ff_ff;
      seg_in     = seg_ff;
      count_in   = count_ff;
      scale_in   = scale_ff;
      if (req_fire) begin
         prev_ff_in = (req_payload.data_byte == MARKER_PREFIX);
         seg_in     = ((pos == '0) || (pos >= WIN_LAST)) ? '0 : pos;
         scale_in   = scale_eff;
         if (marker && count_open) begin
            count_in = count_ff + COUNT_W'(1);
         end
         // drop file context after the last byte
         if (req_payload.end_of_file) begin
            prev_ff_in = 1'b0;
            seg_in     = '0;
            count_in   = '0;
         end
      end
   end

   // ---------------- stage one: scale multiply ----------------
   assign stg_valid_in = req_fire || (stg_valid_ff && !stg_advance);
   assign stg_prod_in  = (PROD_W'(scale_eff) * PROD_W'(req_payload.data_byte)) + ROUND_BIAS;
   assign stg_rew_in   = in_window;

   // ---------------- stage two: divide by 100 and clamp ----------------
   assign quot_full = (QUOT_W*2)'(stg_prod_ff[QUOT_W-1:0]) * (QUOT_W*2)'(RECIP_100);

   always_comb begin
      if (stg_prod_ff < DIV_ONE) begin
         entry = ENTRY_MIN;
      end else if (stg_prod_ff >= DIV_SAT) begin
         entry = ENTRY_MAX;
      end else begin
         entry = quot_full[RECIP_SHIFT+7:RECIP_SHIFT];
      end

      rsp_payload_in.out_byte  = stg_rew_ff ? entry : stg_byte_ff;
      rsp_payload_in.out_last  = stg_last_ff;
      rsp_payload_in.rewritten = stg_rew_ff;
      rsp_valid_in = stg_advance || (rsp_valid_ff && !rsp_ready);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff   <= QUALITY_RESET;
         tsel_ff      <= '0;
         prev_ff_ff   <= 1'b0;
         seg_ff       <= '0;
         count_ff     <= '0;
         scale_ff     <= SCALE_RESET;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quality_ff   <= quality_in;
         tsel_ff      <= tsel_in;
         prev_ff_ff   <= prev_ff_in;
         seg_ff       <= seg_in;
         count_ff     <= count_in;
         scale_ff     <= scale_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_prod_ff <= stg_prod_in;
         stg_byte_ff <= req_payload.data_byte;
         stg_last_ff <= req_payload.end_of_file;
         stg_rew_ff  <= stg_rew_in;
      end
      if (stg_advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // ---------------- assertions ----------------
   a_seg_below_last: assert property (@(posedge clock) disable iff (reset)
      seg_ff < WIN_LAST)
      else $error("segment offset reached the end of the window");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_TABLES))
      else $error("marker count passed its saturation value");

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.end_of_file |=> (seg_ff == '0) && (count_ff == '0) && !prev_ff_ff)
      else $error("file context not cleared after the last byte");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !stg_advance |=> stg_valid_ff && $stable(stg_prod_ff) && $stable(stg_byte_ff))
      else $error("middle stage changed while stalled");

   a_entry_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.rewritten |-> rsp_payload_ff.out_byte != 8'd0)
      else $error("rescaled entry not clamped to one");

endmodule

`default_nettype wire

/* tb/jpeg_dqt_quality_rescaler_tb.sv */
`timescale 1ns / 1ps

module jpeg_dqt_quality_rescaler_tb;
   import jdqr_pkg::*;

   // Stop adding random phases once this many file bytes have gone in.
   localparam int ITEM_TARGET = 550;

   // Segment length field of an 8-bit DQT holding one table: 2 + 1 + 64.
   localparam logic [7:0] DQT_LEN_HI = 8'h00;
   localparam logic [7:0] DQT_LEN_LO = 8'h43;

   // Other markers used to build segments that must pass untouched.
   localparam logic [7:0] OTHER_MARKERS [6] = '{8'hD8, 8'hE0, 8'hC0, 8'hC4, 8'hDA, 8'hFE};

   // Register indexes with no register behind them; writes there change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   // Quality corners visited by the first random phases: lowest, highest,
   // zero (read as one), above range (read as 100), and both sides of 50.
   localparam logic [6:0] QUALITY_CORNERS [6] = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd49, 7'd50};

   // Opening file: quality 0 gives a scale of 5000, so entries clamp high, zero to one.
   // FF FF DB still opens a table; a byte of FF inside the window followed
   // by DB counts as a new marker and, not being selected, closes it.
   localparam logic [7:0] OPENING_FILE [15] = '{
      8'h00, 8'hFF, 8'hFF, 8'hDB, 8'h00, 8'h43, 8'h00, 8'h00,
      8'h01, 8'hFF, 8'h80, 8'hFF, 8'hDB, 8'h05, 8'h07
   };

   // Second file: quality 127 gives a scale of 0, so entries clamp to one.
   // The second marker is the selected one; the file ends inside the window
   // on an FF, which must not pair with the DB that may follow.
   localparam logic [7:0] SECOND_FILE [11] = '{
      8'hFF, 8'hDB, 8'h12, 8'hFF, 8'hDB, 8'h00, 8'h43, 8'h00,
      8'h9A, 8'h00, 8'hFF
   };

   // Tracks the marker state of the stream, works out each returned byte
   // and holds the bytes still owed by the block.
   class dqt_tracker;
      logic [6:0]  quality_reg;
      logic [3:0]  select_reg;
      bit          after_ff;
      int unsigned table_pos;
      int unsigned dqt_seen;
      int unsigned scale_pct;
      rsp_type     pending_bytes[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned rescaled;
      int unsigned files;

      function new();
         quality_reg = QUALITY_RESET;
         select_reg  = '0;
         after_ff    = 1'b0;
         table_pos   = 0;
         dqt_seen    = 0;
         scale_pct   = SCALE_RESET;
         mismatches  = 0;
         checked     = 0;
         rescaled    = 0;
         files       = 0;
      endfunction

      // Scale in percent: 5000/q below 50, 200-2q from 50 up; q is held to 1..100.
      function int unsigned percent_for(logic [6:0] q);
         int unsigned qq;
         qq = (q == 0) ? 1 : ((q > 100) ? 100 : q);
         return (qq < 50) ? 5000 / qq : 200 - 2 * qq;
      endfunction

      function logic [7:0] scaled_entry(logic [7:0] v);
         int unsigned r;
         r = (scale_pct * v + 50) / 100;
         if (r == 0) r = 1;
         if (r > 255) r = 255;
         return r[7:0];
      endfunction

      function void note_config(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_QUALITY:      quality_reg = val;
            CSR_TABLE_SELECT: select_reg  = val[3:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type rq);
         int unsigned pos;
         bit          selected;
         rsp_type     rs;
         pos = 0;
         // Follow quality while no table is open, and again when the selected table restarts.
         if (table_pos == 0) scale_pct = percent_for(quality_reg);
         if (after_ff && rq.data_byte == MARKER_DQT) begin
            selected = (dqt_seen < MAX_TABLES) && (dqt_seen == select_reg);
            if (dqt_seen < MAX_TABLES) dqt_seen++;
            if (selected) begin
               scale_pct = percent_for(quality_reg);
               pos = 1;
            end
         end else if (table_pos != 0) begin
            pos = table_pos + 1;
         end
         rs.out_byte  = rq.data_byte;
         rs.out_last  = rq.end_of_file;
         rs.rewritten = 1'b0;
         if (pos >= TABLE_START_OFFSET && pos < TABLE_START_OFFSET + TABLE_ENTRIES) begin
            rs.out_byte  = scaled_entry(rq.data_byte);
            rs.rewritten = 1'b1;
            rescaled++;
         end
         table_pos = (pos >= TABLE_START_OFFSET + TABLE_ENTRIES - 1) ? 0 : pos;
         // Detection looks at the incoming byte, never the rewritten one.
         after_ff = (rq.data_byte == MARKER_PREFIX);
         if (rq.end_of_file) begin
            after_ff  = 1'b0;
            table_pos = 0;
            dqt_seen  = 0;
            files++;
         end
         pending_bytes = {pending_bytes, rs};
      endfunction

      // Count every mismatch, print only the first few to keep the log short.
      function void report(string what);
         mismatches++;
         if (mismatches <= 30) $display("%0t mismatch: %s", $time, what);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("response %h with no request waiting", got));
            return;
         end
         want = pending_bytes.pop_front();
         checked++;
         if (got.out_byte !== want.out_byte)
            report($sformatf("byte %0d out_byte %h, want %h", checked, got.out_byte,
                             want.out_byte));
         if (got.out_last !== want.out_last)
            report($sformatf("byte %0d out_last %b, want %b", checked, got.out_last,
                             want.out_last));
         if (got.rewritten !== want.rewritten)
            report($sformatf("byte %0d rewritten %b, want %b", checked, got.rewritten,
                             want.rewritten));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid   = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   dqt_tracker tracker;

   // Handshake results of the last rising edge, read by the drivers at the falling edge.
   bit req_took;
   bit csr_took;

   req_type     stream_q[$];
   int unsigned bytes_sent;
   int unsigned reg_writes;
   int          burst_left;
   bit          sender_gaps;

   // Receiver stall pattern: a 16-bit mask stepped once per cycle, redrawn now and then.
   logic [15:0] ready_mask = 16'hFFFF;
   int          ready_left = 0;

   jpeg_dqt_quality_rescaler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sample all three channels at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      csr_took = !reset && csr_valid && csr_ready;
      if (req_took) tracker.note_request(req_payload);
      if (csr_took) tracker.note_config(csr_index, csr_data);
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_payload);
   end

   // Drive ready from the current mask: no stalls, random, sparse, or mostly stalled.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_left = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0:       ready_mask = 16'hFFFF;
            1:       ready_mask = 16'($urandom()) | 16'h0001;
            2:       ready_mask = 16'h0101;
            default: ready_mask = (16'($urandom()) & 16'($urandom())) | 16'h8000;
         endcase
      end
      ready_left--;
      rsp_ready <= ready_mask[ready_left % 16];
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("jpeg_dqt_quality_rescaler_tb: errors");
      $finish;
   end

   function automatic void add_byte(logic [7:0] b);
      req_type rq;
      rq.data_byte   = b;
      rq.end_of_file = 1'b0;
      stream_q = {stream_q, rq};
   endfunction

   function automatic logic [7:0] entry_value(int unsigned flavor);
      case (flavor)
         0:       return 8'($urandom());
         1:       return 8'($urandom_range(0, 3));
         2:       return 8'($urandom_range(200, 255));
         default: begin
            case ($urandom_range(0, 3))
               0:       return 8'h00;
               1:       return 8'h01;
               2:       return 8'hFE;
               default: return 8'hFF;
            endcase
         end
      endcase
   endfunction

   // Append one DQT segment; cut it short to leave the window open, and now
   // and then drop a fresh FF DB into the entries to restart the count.
   function automatic void add_table(bit cut);
      int unsigned n;
      int unsigned flavor;
      int unsigned restart_at;
      n          = cut ? $urandom_range(8, 56) : TABLE_ENTRIES;
      flavor     = $urandom_range(0, 3);
      restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(2, n - 2) : n + 10;
      add_byte(MARKER_PREFIX);
      add_byte(MARKER_DQT);
      add_byte(DQT_LEN_HI);
      add_byte(DQT_LEN_LO);
      add_byte({4'h0, 4'($urandom_range(0, 3))});
      for (int i = 0; i < n; i++) begin
         if (i == restart_at) begin
            add_byte(MARKER_PREFIX);
            add_byte(MARKER_DQT);
         end else begin
            add_byte(entry_value(flavor));
         end
      end
   endfunction

   function automatic void add_other_segment();
      int unsigned n;
      n = $urandom_range(0, 6);
      add_byte(MARKER_PREFIX);
      add_byte(OTHER_MARKERS[$urandom_range(0, 5)]);
      add_byte(8'h00);
      add_byte(8'(n + 2));
      for (int i = 0; i < n; i++) add_byte(8'($urandom()));
   endfunction

   // Noise rich in FF and DB so stray pairs turn up.
   function automatic void add_noise(int unsigned n);
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 3) add_byte(MARKER_PREFIX);
         else if (r == 3) add_byte(MARKER_DQT);
         else add_byte(8'($urandom()));
      end
   endfunction

   // Bare markers, each followed by one byte that cannot start another.
   function automatic void add_marker_run(int unsigned k);
      for (int i = 0; i < k; i++) begin
         add_byte(MARKER_PREFIX);
         add_byte(MARKER_DQT);
         add_byte(8'($urandom_range(0, 254)));
      end
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(negedge clock); while (!csr_took);
      csr_valid = 1'b0;
      reg_writes++;
   endtask

   // Drain the stream queue, one request per accepted handshake, in bursts
   // separated by idle gaps when gaps are on for this phase.
   task automatic send_stream();
      req_type item;
      while (stream_q.size() > 0) begin
         item = stream_q.pop_front();
         if (burst_left <= 0) begin
            if (sender_gaps) begin
               req_valid = 1'b0;
               repeat ($urandom_range(1, 6)) @(negedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end
         req_valid   = 1'b1;
         req_payload = item;
         do @(negedge clock); while (!req_took);
         bytes_sent++;
         burst_left--;
      end
      req_valid = 1'b0;
   endtask

   // Every request returns exactly one byte, so an empty queue means an idle block.
   task automatic wait_idle();
      while (tracker.pending_bytes.size() != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned phase;
      int          run;
      logic [6:0]  q;
      logic [3:0]  sel;
      tracker     = new();
      bytes_sent  = 0;
      reg_writes  = 0;
      burst_left  = 0;
      sender_gaps = 1'b0;
      // Hold reset, then release it on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: quality zero, selected first table, clamps at both ends.
      write_reg(CSR_QUALITY, 7'd0);
      write_reg(CSR_TABLE_SELECT, 7'd0);
      foreach (OPENING_FILE[i]) add_byte(OPENING_FILE[i]);
      stream_q[$].end_of_file = 1'b1;
      send_stream();
      wait_idle();

      // Directed: quality above range, second marker selected, spare indexes ignored.
      write_reg(CSR_QUALITY, 7'd127);
      write_reg(CSR_TABLE_SELECT, 7'd1);
      write_reg(CSR_SPARE_LO, 7'($urandom()));
      write_reg(CSR_SPARE_HI, 7'($urandom()));
      foreach (SECOND_FILE[i]) add_byte(SECOND_FILE[i]);
      stream_q[$].end_of_file = 1'b1;
      sender_gaps = 1'b1;
      send_stream();

      // Random phases: new settings while idle, then a slice of file bytes.
      // A slice may stop inside an open table, so the next write lands
      // while a table is open and must not touch the held scale.
      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         wait_idle();
         if (phase < 6) begin
            q = QUALITY_CORNERS[phase];
         end else if ($urandom_range(0, 7) == 0) begin
            q = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(101, 127));
         end else begin
            q = 7'($urandom_range(1, 100));
         end
         // Mostly aim at the next marker so tables really get rescaled.
         if (tracker.dqt_seen < MAX_TABLES && $urandom_range(0, 9) < 7) begin
            sel = 4'(tracker.dqt_seen);
         end else begin
            sel = 4'($urandom_range(0, 15));
         end
         run = -1;
         if ($urandom_range(0, 5) == 0) begin
            // Long marker runs: hit the last selectable table, or saturate the count.
            sel = 4'(MAX_TABLES - 1);
            if (tracker.dqt_seen < MAX_TABLES && $urandom_range(0, 1) == 0) begin
               run = MAX_TABLES - 1 - tracker.dqt_seen;
            end else begin
               run = $urandom_range(MAX_TABLES, MAX_TABLES + 4);
            end
         end
         if (phase < 6 || $urandom_range(0, 9) < 7) write_reg(CSR_QUALITY, q);
         if (phase < 6 || run >= 0 || $urandom_range(0, 9) < 7)
            write_reg(CSR_TABLE_SELECT, {3'($urandom()), sel});

         if (run >= 0) begin
            add_marker_run(run);
            add_table(1'b0);
            stream_q[$].end_of_file = 1'b1;
         end else begin
            for (int s = $urandom_range(1, 2); s > 0; s--) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: add_table($urandom_range(0, 5) == 0);
                  6, 7:             add_other_segment();
                  default:          add_noise($urandom_range(1, 8));
               endcase
            end
            if ($urandom_range(0, 4) < 3) stream_q[$].end_of_file = 1'b1;
         end
         sender_gaps = ($urandom_range(0, 3) != 0);
         send_stream();
         phase++;
      end

      // Drain, then wait on so a stray byte still in either of the two stages can show.
      for (int n = 0; n < 5000 && tracker.pending_bytes.size() != 0; n++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (tracker.pending_bytes.size() != 0)
         tracker.report($sformatf("%0d bytes never returned", tracker.pending_bytes.size()));

      $display("run: %0d bytes in %0d files over %0d phases, %0d register writes",
               bytes_sent, tracker.files, phase + 2, reg_writes);
      $display("run: %0d bytes checked, %0d of them rescaled table entries",
               tracker.checked, tracker.rescaled);
      if (tracker.mismatches == 0) begin
         $display("jpeg_dqt_quality_rescaler_tb: clean");
      end else begin
         $display("jpeg_dqt_quality_rescaler_tb: errors");
      end
      $finish;
   end

endmodule
